// File: sv/spi_pkg.sv
// Package: widths, constants and types shared by the segment/plane intersect pipeline.
`timescale 1ns / 1ps
package spi_pkg;
	localparam int COORD_W      = 32;
	localparam int LIMIT_W      = 17;
	localparam int FRAC_BITS_DEF = 16;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd655;
	// direction and offset components need one extra bit
	localparam int DIFF_W = COORD_W + 1;
	// product of a 32-bit normal and a 33-bit difference
	localparam int PROD_W = COORD_W + DIFF_W;
	// sum of three products
	localparam int DOT_W  = PROD_W + 2;
	// magnitude of a dot product
	localparam int MAG_W  = DOT_W - 1;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x, start_y, start_z;
		logic signed [COORD_W-1:0] end_x, end_y, end_z;
		logic signed [COORD_W-1:0] plane_point_x, plane_point_y, plane_point_z;
		logic signed [COORD_W-1:0] normal_x, normal_y, normal_z;
	} req_t;

	typedef struct packed {
		logic                      hit;
		logic signed [COORD_W-1:0] hit_x, hit_y, hit_z;
	} rsp_t;
endpackage

// File: sv/spi_if.sv
// Valid/ready channel interface carrying a generic payload.
`timescale 1ns / 1ps
interface spi_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/segment_plane_intersect.sv
// Top level: segment/plane intersection pipeline with an output register.
`timescale 1ns / 1ps
// Fully pipelined: one request per cycle while the pipeline advances (four dot product
// stages, FRAC_BITS + 2 divider stages, two interpolation stages, and the output
// register). The pipeline advances whenever the output register is empty or taken, so
// while a response waits req.ready follows rsp.ready combinationally. limit_q
// resets to 655.
module segment_plane_intersect #(
	parameter int FRAC_BITS = spi_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [spi_pkg::LIMIT_W-1:0] cfg_wdata,
	spi_if.sink                         req,
	spi_if.source                       rsp
);
	import spi_pkg::*;

	logic [LIMIT_W-1:0]   limit_q;
	logic                 en;
	logic                 dv, dok, pv, phit;
	logic [MAG_W-1:0]     dnum, dden;
	logic [3*COORD_W-1:0] dst, pxyz;
	logic [3*DIFF_W-1:0]  ddir;
	logic                 ov_q;
	logic [3*COORD_W:0]   od_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= LIMIT_RESET;
		else if (cfg_we) limit_q <= cfg_wdata;
	end

	// advance when the output slot is free or being taken
	assign en        = !ov_q || rsp.ready;
	assign req.ready = en;

	spi_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
		.clk, .arst_n, .en,
		.in_valid (req.valid),
		.in_start ({req.data.start_z, req.data.start_y, req.data.start_x}),
		.in_end   ({req.data.end_z, req.data.end_y, req.data.end_x}),
		.in_point ({req.data.plane_point_z, req.data.plane_point_y,
			req.data.plane_point_x}),
		.in_normal({req.data.normal_z, req.data.normal_y, req.data.normal_x}),
		.limit    (limit_q),
		.out_valid(dv), .out_ok(dok), .out_num(dnum), .out_den(dden),
		.out_start(dst), .out_dir(ddir)
	);

	spi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk, .arst_n, .en,
		.in_valid(dv), .in_ok(dok), .in_num(dnum), .in_den(dden),
		.in_start(dst), .in_dir(ddir),
		.out_valid(pv), .out_hit(phit), .out_xyz(pxyz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (en) ov_q <= pv;
	end

	always_ff @(posedge clk) begin
		if (en) od_q <= {phit, pxyz};
	end

	assign rsp.valid      = ov_q;
	assign rsp.data.hit   = od_q[3*COORD_W];
	assign rsp.data.hit_x = od_q[COORD_W-1:0];
	assign rsp.data.hit_y = od_q[2*COORD_W-1:COORD_W];
	assign rsp.data.hit_z = od_q[3*COORD_W-1:2*COORD_W];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !rsp.ready |=> ov_q && $stable(od_q))
		else $error("response dropped under stall");
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !od_q[3*COORD_W] |-> od_q[3*COORD_W-1:0] == '0)
		else $error("miss with nonzero point");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!ov_q |-> req.ready)
		else $error("stalled with empty output");
endmodule

// File: sv/spi_dot.sv
// Dot product stages: differences, products, sums, magnitude and miss tests.
`timescale 1ns / 1ps
module spi_dot #(
	parameter int FRAC_BITS = spi_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [3*spi_pkg::COORD_W-1:0] in_start,
	input  logic [3*spi_pkg::COORD_W-1:0] in_end,
	input  logic [3*spi_pkg::COORD_W-1:0] in_point,
	input  logic [3*spi_pkg::COORD_W-1:0] in_normal,
	input  logic [spi_pkg::LIMIT_W-1:0]   limit,
	output logic                          out_valid,
	output logic                          out_ok,
	output logic [spi_pkg::MAG_W-1:0]     out_num,
	output logic [spi_pkg::MAG_W-1:0]     out_den,
	output logic [3*spi_pkg::COORD_W-1:0] out_start,
	output logic [3*spi_pkg::DIFF_W-1:0]  out_dir
);
	import spi_pkg::*;

	logic                            v_s1, v_s2, v_s3, v_s4;
	logic signed [DIFF_W-1:0]        d_s1 [3];
	logic signed [DIFF_W-1:0]        l_s1 [3];
	logic signed [COORD_W-1:0]       n_s1 [3];
	logic [3*COORD_W-1:0]            st_s1, st_s2, st_s3;
	logic signed [PROD_W-1:0]        pd_s2 [3];
	logic signed [PROD_W-1:0]        pl_s2 [3];
	logic [3*DIFF_W-1:0]             dir_s2, dir_s3;
	logic signed [DOT_W-1:0]         den_s3, num_s3;
	logic [MAG_W-1:0]                den_s4, num_s4;
	logic                            ok_s4;
	logic [3*COORD_W-1:0]            st_s4;
	logic [3*DIFF_W-1:0]             dir_s4, dir_s1;
	logic signed [DOT_W-1:0]         den_abs, num_adj;
	logic [MAG_W+FRAC_BITS-1:0]      lim_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			dir_s1[i*DIFF_W +: DIFF_W] = d_s1[i];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= DIFF_W'($signed(in_end[i*COORD_W +: COORD_W]))
					- DIFF_W'($signed(in_start[i*COORD_W +: COORD_W]));
				l_s1[i] <= DIFF_W'($signed(in_point[i*COORD_W +: COORD_W]))
					- DIFF_W'($signed(in_start[i*COORD_W +: COORD_W]));
				n_s1[i] <= $signed(in_normal[i*COORD_W +: COORD_W]);
				pd_s2[i] <= PROD_W'(n_s1[i]) * PROD_W'(d_s1[i]);
				pl_s2[i] <= PROD_W'(n_s1[i]) * PROD_W'(l_s1[i]);
			end
			st_s1  <= in_start;
			st_s2  <= st_s1;
			st_s3  <= st_s2;
			st_s4  <= st_s3;
			dir_s2 <= dir_s1;
			dir_s3 <= dir_s2;
			dir_s4 <= dir_s3;
			den_s3 <= DOT_W'(pd_s2[0]) + DOT_W'(pd_s2[1]) + DOT_W'(pd_s2[2]);
			num_s3 <= DOT_W'(pl_s2[0]) + DOT_W'(pl_s2[1]) + DOT_W'(pl_s2[2]);
			den_s4 <= MAG_W'(den_abs);
			num_s4 <= MAG_W'(num_adj);
			ok_s4  <= (den_s3 != '0) && !num_adj[DOT_W-1]
				&& ((MAG_W+FRAC_BITS)'(MAG_W'(den_abs)) >= lim_w)
				&& (MAG_W'(den_abs) >= MAG_W'(num_adj));
		end
	end

	// flip both signs so the denominator is positive
	assign den_abs = den_s3[DOT_W-1] ? -den_s3 : den_s3;
	assign num_adj = den_s3[DOT_W-1] ? -num_s3 : num_s3;
	assign lim_w   = (MAG_W+FRAC_BITS)'(limit) << FRAC_BITS;

	assign out_valid = v_s4;
	assign out_ok    = ok_s4;
	assign out_num   = num_s4;
	assign out_den   = den_s4;
	assign out_start = st_s4;
	assign out_dir   = dir_s4;
endmodule

// File: sv/spi_div.sv
// Pipelined restoring divider for the quantized ratio, then interpolation stages.
`timescale 1ns / 1ps
module spi_div #(
	parameter int FRAC_BITS = spi_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic                          in_ok,
	input  logic [spi_pkg::MAG_W-1:0]     in_num,
	input  logic [spi_pkg::MAG_W-1:0]     in_den,
	input  logic [3*spi_pkg::COORD_W-1:0] in_start,
	input  logic [3*spi_pkg::DIFF_W-1:0]  in_dir,
	output logic                          out_valid,
	output logic                          out_hit,
	output logic [3*spi_pkg::COORD_W-1:0] out_xyz
);
	import spi_pkg::*;

	localparam int STEPS = FRAC_BITS + 1;
	localparam int TQ_W  = FRAC_BITS + 1;
	localparam int REM_W = MAG_W + 1;
	localparam int MUL_W = DIFF_W - 1 + TQ_W;

	logic                 v_q   [STEPS+1];
	logic                 ok_q  [STEPS+1];
	logic [REM_W-1:0]     rem_q [STEPS+1];
	logic [MAG_W-1:0]     den_q [STEPS+1];
	logic [TQ_W-1:0]      tq_q  [STEPS+1];
	logic [3*COORD_W-1:0] st_q  [STEPS+1];
	logic [3*DIFF_W-1:0]  dir_q [STEPS+1];

	logic                 v_m1, ok_m1, v_m2, hit_m2;
	logic [MUL_W-1:0]     step_m1 [3];
	logic                 neg_m1  [3];
	logic [3*COORD_W-1:0] st_m1, xyz_m2;

	// one quotient bit per stage from stage 1 on; stage 1 gets the integer bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= STEPS; k++) v_q[k] <= 1'b0;
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
			for (int k = 1; k <= STEPS; k++) v_q[k] <= v_q[k-1];
			v_m1 <= v_q[STEPS];
			v_m2 <= v_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_q[0]  <= in_ok;
			rem_q[0] <= REM_W'(in_num);
			den_q[0] <= in_den;
			tq_q[0]  <= '0;
			st_q[0]  <= in_start;
			dir_q[0] <= in_dir;
			for (int k = 1; k <= STEPS; k++) begin
				logic [REM_W-1:0] r;
				r = (k == 1) ? rem_q[k-1] : (rem_q[k-1] << 1);
				ok_q[k]  <= ok_q[k-1];
				den_q[k] <= den_q[k-1];
				st_q[k]  <= st_q[k-1];
				dir_q[k] <= dir_q[k-1];
				if (r >= REM_W'(den_q[k-1])) begin
					rem_q[k] <= r - REM_W'(den_q[k-1]);
					tq_q[k]  <= TQ_W'({tq_q[k-1], 1'b1});
				end else begin
					rem_q[k] <= r;
					tq_q[k]  <= TQ_W'({tq_q[k-1], 1'b0});
				end
			end
			ok_m1 <= ok_q[STEPS];
			st_m1 <= st_q[STEPS];
			for (int i = 0; i < 3; i++) begin
				logic signed [DIFF_W-1:0] d;
				logic [DIFF_W-1:0]        mag;
				d   = $signed(dir_q[STEPS][i*DIFF_W +: DIFF_W]);
				mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
				neg_m1[i]  <= d[DIFF_W-1];
				step_m1[i] <= MUL_W'(mag) * MUL_W'(tq_q[STEPS]);
			end
			hit_m2 <= ok_m1;
			for (int i = 0; i < 3; i++) begin
				logic [COORD_W-1:0] s, st;
				s  = st_m1[i*COORD_W +: COORD_W];
				st = COORD_W'(step_m1[i] >> FRAC_BITS);
				xyz_m2[i*COORD_W +: COORD_W] <= !ok_m1 ? '0
					: (neg_m1[i] ? s - st : s + st);
			end
		end
	end

	assign out_valid = v_m2;
	assign out_hit   = hit_m2;
	assign out_xyz   = xyz_m2;
endmodule

// File: dv/tb_top.sv
// Testbench for segment_plane_intersect: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
	import spi_pkg::*;

	localparam int FRAC    = FRAC_BITS_DEF;
	localparam int LATENCY = FRAC + 9;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic [31:0] ONE = 32'h0001_0000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [LIMIT_W-1:0] cfg_wdata;

	spi_if #(.payload_t(req_t)) req_ch ();
	spi_if #(.payload_t(rsp_t)) rsp_ch ();

	segment_plane_intersect dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	rsp_t pending_points[$];
	logic [LIMIT_W-1:0] model_limit;
	int errors;
	int quiet_cycles;
	int stall_left;
	bit calm;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// exact widened arithmetic, t quantized to FRAC bits, offset truncated toward zero
	function automatic rsp_t intersect_point(req_t it, logic [LIMIT_W-1:0] lim);
		logic signed [127:0] s[3], e[3], p[3], n[3];
		logic signed [127:0] d, den, num, lim_w, c;
		logic [127:0] tq, mag, step;
		rsp_t r;
		s[0] = it.start_x;       s[1] = it.start_y;       s[2] = it.start_z;
		e[0] = it.end_x;         e[1] = it.end_y;         e[2] = it.end_z;
		p[0] = it.plane_point_x; p[1] = it.plane_point_y; p[2] = it.plane_point_z;
		n[0] = it.normal_x;      n[1] = it.normal_y;      n[2] = it.normal_z;
		r = '0;
		den = 0;
		num = 0;
		for (int i = 0; i < 3; i++) begin
			den += n[i] * (e[i] - s[i]);
			num += n[i] * (p[i] - s[i]);
		end
		if (den == 0) return r;
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		lim_w = {111'b0, lim};
		lim_w = lim_w << FRAC;
		if (den < lim_w || num < 0 || num > den) return r;
		tq = (num <<< FRAC) / den;
		r.hit = 1'b1;
		for (int i = 0; i < 3; i++) begin
			d = e[i] - s[i];
			mag = (d < 0) ? -d : d;
			step = (mag * tq) >> FRAC;
			c = (d < 0) ? s[i] - signed'(step) : s[i] + signed'(step);
			case (i)
				0: r.hit_x = c[31:0];
				1: r.hit_y = c[31:0];
				default: r.hit_z = c[31:0];
			endcase
		end
		return r;
	endfunction

	function automatic req_t mk(logic [31:0] sx, sy, sz, ex, ey, ez, px, py, pz, nx, ny, nz);
		req_t it;
		it = '{sx, sy, sz, ex, ey, ez, px, py, pz, nx, ny, nz};
		return it;
	endfunction

	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			3: return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
			4: return $urandom_range(0, 32'h0000_0400) - 32'h0000_0200;
			default: case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0;
				default: return 32'hFFFF_FFFF;
			endcase
		endcase
	endfunction

	// plane point placed on the segment at a random t, so most of these hit
	function automatic req_t crossing_item();
		req_t it;
		longint s, e, f;
		logic [31:0] pt[3];
		it = mk(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
			0, 0, 0, rnd_coord(), rnd_coord(), rnd_coord());
		f = $urandom_range(0, 65536);
		for (int i = 0; i < 3; i++) begin
			s = (i == 0) ? longint'(it.start_x) : (i == 1) ? longint'(it.start_y)
				: longint'(it.start_z);
			e = (i == 0) ? longint'(it.end_x) : (i == 1) ? longint'(it.end_y)
				: longint'(it.end_z);
			pt[i] = s + (((e - s) * f) >>> 16);
		end
		it.plane_point_x = pt[0];
		it.plane_point_y = pt[1];
		it.plane_point_z = pt[2];
		if ($urandom_range(0, 5) == 0) it.plane_point_z ^= 32'h1 << $urandom_range(0, 31);
		return it;
	endfunction

	function automatic req_t noise_item();
		return mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endfunction

	task automatic send_request(req_t it);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= it;
		do @(posedge clk); while (!req_ch.ready);
		pending_points.push_back(intersect_point(it, model_limit));
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_points.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_W-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_limit = v;
	endtask

	task automatic test_directed();
		logic [31:0] two, m, x;
		two = 2 * ONE;
		m = 32'h8000_0000;
		x = 32'h7FFF_FFFF;
		send_request(mk(0, 0, 0, 0, 0, two, 0, 0, ONE, 0, 0, ONE));
		send_request(mk(0, 0, 0, 0, 0, two, 0, 0, 0, 0, 0, ONE));
		send_request(mk(0, 0, 0, 0, 0, two, 0, 0, two, 0, 0, ONE));
		send_request(mk(0, 0, 0, 0, 0, two, 0, 0, -ONE, 0, 0, ONE));
		send_request(mk(0, 0, 0, 0, 0, two, 0, 0, 3 * ONE, 0, 0, ONE));
		send_request(mk(0, 0, 0, 0, 0, two, 0, 0, ONE, ONE, 0, 0));
		send_request(mk(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, ONE));
		send_request(mk(ONE, ONE, ONE, -ONE, -ONE, -ONE, 0, 0, 0, 0, -ONE, 0));
		send_request(mk(m, m, m, x, x, x, 0, 0, 0, m, x, m));
		send_request(mk(x, m, x, m, x, m, 0, 0, 0, x, x, x));
		send_request(mk(m, m, m, x, x, x, x, x, x, x, x, x));
		send_request(mk(m, m, m, x, x, x, m, m, m, m, m, m));
		send_request(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_request(mk(x, x, x, x, x, x, x, x, x, m, m, m));
	endtask

	task automatic test_random(int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 3) == 0) send_request(noise_item());
			else send_request(crossing_item());
		end
	endtask

	// limit 0 must still reject zero den; a limit of 0x10000 rejects |N.D| below 1.0
	task automatic test_limit_extremes();
		write_limit(0);
		send_request(mk(0, 0, 0, 0, 0, ONE, 0, 0, ONE, ONE, 0, 0));
		send_request(mk(0, 0, 0, 0, 0, 1, 0, 0, 1, 0, 0, 1));
		test_random(120);
		write_limit(17'h10000);
		send_request(mk(0, 0, 0, 0, 0, ONE, 0, 0, 0, 0, 0, ONE));
		send_request(mk(0, 0, 0, 0, 0, ONE - 1, 0, 0, 0, 0, 0, ONE));
		send_request(mk(0, 0, 0, 0, 0, ONE, 0, 0, 0, 0, 0, -ONE));
		test_random(120);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left--;
		end else if (!calm && $urandom_range(0, 6) == 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left = $urandom_range(0, 4);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		rsp_t exp_pt;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_points.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time,
					rsp_ch.data);
				errors++;
			end else begin
				exp_pt = pending_points.pop_front();
				if (rsp_ch.data.hit !== exp_pt.hit) begin
					$display("%0t: hit expected %0b actual %0b", $time, exp_pt.hit,
						rsp_ch.data.hit);
					errors++;
				end
				if (rsp_ch.data.hit_x !== exp_pt.hit_x) begin
					$display("%0t: hit_x expected %0d actual %0d", $time, exp_pt.hit_x,
						rsp_ch.data.hit_x);
					errors++;
				end
				if (rsp_ch.data.hit_y !== exp_pt.hit_y) begin
					$display("%0t: hit_y expected %0d actual %0d", $time, exp_pt.hit_y,
						rsp_ch.data.hit_y);
					errors++;
				end
				if (rsp_ch.data.hit_z !== exp_pt.hit_z) begin
					$display("%0t: hit_z expected %0d actual %0d", $time, exp_pt.hit_z,
						rsp_ch.data.hit_z);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles = 0;
		end else if (arst_n) begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: timeout", $time);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		errors       = 0;
		quiet_cycles = 0;
		calm         = 1'b0;
		model_limit  = LIMIT_RESET;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(220);
		test_limit_extremes();
		write_limit(LIMIT_W'($urandom_range(1, 17'h0FFFF)));
		test_random(100);
		write_limit(LIMIT_RESET);
		calm = 1'b1;
		test_random(180);
		drain();
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
